// File: sv/sm3_pkg.sv
// shared types, constants and helper functions of the sm3 hash engine
package sm3_pkg;

   typedef logic [31:0] word_type;

   localparam word_type T_LOW      = 32'h79cc4519;
   // high round constant already rotated by sixteen, the amount it needs at round sixteen
   localparam word_type T_HIGH_R16 = 32'h9d8a7a87;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [2:0] MAX_BYTES = 3'd4;

   localparam word_type IV [8] = '{
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };

   typedef struct packed {
      logic [31:0] message_word;
      logic [2:0]  valid_bytes;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        digest_last;
   } rsp_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
      word_type f;
      word_type g;
      word_type h;
   } sm3_work_type;

   typedef struct packed {
      word_type t_rot;
      word_type w_j;
      word_type w_j4;
      logic     round_hi;
   } sm3_rctl_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_BYTES, ST_PAD80, ST_ZERO, ST_LEN, ST_COMP, ST_OUT
   } st_type;

   // rotate left by a constant amount between 1 and 31
   function automatic word_type rotl(word_type x, int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic word_type perm0(word_type x);
      return x ^ rotl(x, 9) ^ rotl(x, 17);
   endfunction

   function automatic word_type perm1(word_type x);
      return x ^ rotl(x, 15) ^ rotl(x, 23);
   endfunction

endpackage

// File: sv/sm3_round.sv
// one sm3 compression round, shared by all 64 rounds
module sm3_round import sm3_pkg::*; (
   input  sm3_work_type cur,
   input  sm3_rctl_type ctl,
   output sm3_work_type nxt
);

   word_type a12, ss1, ss2, ff, gg, tt1, tt2;

   always_comb begin
      a12 = rotl(cur.a, 12);
      ss1 = rotl(a12 + cur.e + ctl.t_rot, 7);
      ss2 = ss1 ^ a12;
      if (ctl.round_hi) begin
         ff = (cur.a & cur.b) | (cur.a & cur.c) | (cur.b & cur.c);
         gg = (cur.e & cur.f) | (~cur.e & cur.g);
      end else begin
         ff = cur.a ^ cur.b ^ cur.c;
         gg = cur.e ^ cur.f ^ cur.g;
      end
      tt1 = ff + cur.d + ss2 + (ctl.w_j ^ ctl.w_j4);
      tt2 = gg + cur.h + ss1 + ctl.w_j;
      nxt.a = tt1;
      nxt.b = cur.a;
      nxt.c = rotl(cur.b, 9);
      nxt.d = cur.c;
      nxt.e = perm0(tt2);
      nxt.f = cur.e;
      nxt.g = rotl(cur.f, 19);
      nxt.h = cur.g;
   end

endmodule

// File: sv/sm3_hash_engine_core.sv
// sm3 hash engine top level: byte packing, padding, round sequencer and digest output
//
// sm3 hash engine. message words arrive on req_ (big-endian, valid_bytes leading
// bytes count, 5..7 treated as 4) and the 256-bit digest leaves on rsp_ as eight
// words, word 0 first, digest_last on the eighth. the engine handles one word at
// a time and holds req_ready low while busy. bytes go into the block window one
// per cycle, paused while a compression runs: a word is accepted, its bytes are
// written in turn, and a closing step returns to idle or starts the padding. every
// full 512-bit block runs 64 compression rounds through a single shared round
// unit, one round per cycle, with the message schedule produced on the fly by a
// 16-word shift window. on the last word the padding is also written one byte
// per cycle (plus a second compression when the length no longer fits), then the
// eight digest words are offered, one per accepted rsp_ cycle, and the initial
// value reloads.
module sm3_hash_engine_core import sm3_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   st_type       state_ff, state_in, ret_ff, ret_in;
   word_type     cv_ff [8];
   word_type     cv_in [8];
   word_type     w_ff [16];
   word_type     w_in [16];
   sm3_work_type work_ff, work_in, round_out;
   sm3_rctl_type rctl;
   word_type     t_ff, t_in, w_next;
   logic [5:0]   fill_ff, fill_in, round_ff, round_in;
   logic [63:0]  len_ff, len_in;
   logic [31:0]  word_ff, word_in;
   logic [2:0]   nbytes_ff, nbytes_in, cnt_ff, cnt_in, out_idx_ff, out_idx_in;
   logic         last_ff, last_in;
   logic         put_en;
   logic [7:0]   put_byte;
   st_type       after_put;

   // message expansion: w[j+16] from the window taps
   assign w_next = perm1(w_ff[0] ^ w_ff[7] ^ rotl(w_ff[13], 15))
                   ^ rotl(w_ff[3], 7) ^ w_ff[10];

   assign rctl.t_rot    = t_ff;
   assign rctl.w_j      = w_ff[0];
   assign rctl.w_j4     = w_ff[4];
   assign rctl.round_hi = (round_ff >= 6'd16);

   sm3_round u_round (
      .cur (work_ff),
      .ctl (rctl),
      .nxt (round_out)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_payload.digest_word = cv_ff[out_idx_ff];
   assign rsp_payload.digest_last = (out_idx_ff == 3'd7);

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      cv_in      = cv_ff;
      w_in       = w_ff;
      work_in    = work_ff;
      t_in       = t_ff;
      fill_in    = fill_ff;
      round_in   = round_ff;
      len_in     = len_ff;
      word_in    = word_ff;
      nbytes_in  = nbytes_ff;
      cnt_in     = cnt_ff;
      out_idx_in = out_idx_ff;
      last_in    = last_ff;
      put_en     = 1'b0;
      put_byte   = '0;
      after_put  = state_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               word_in   = req_payload.message_word;
               nbytes_in = (req_payload.valid_bytes > MAX_BYTES) ? MAX_BYTES
                                                                  : req_payload.valid_bytes;
               last_in   = req_payload.last_word;
               cnt_in    = '0;
               state_in  = ST_BYTES;
            end
         end
         ST_BYTES: begin
            if (cnt_ff < nbytes_ff) begin
               put_en    = 1'b1;
               put_byte  = word_ff[{~cnt_ff[1:0], 3'b000} +: 8];
               cnt_in    = cnt_ff + 3'd1;
               len_in    = len_ff + 64'd8;
               after_put = ST_BYTES;
            end else if (last_ff) begin
               state_in = ST_PAD80;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD80: begin
            put_en    = 1'b1;
            put_byte  = PAD_BYTE;
            after_put = ST_ZERO;
         end
         ST_ZERO: begin
            if (fill_ff == LEN_POS) begin
               cnt_in   = '0;
               state_in = ST_LEN;
            end else begin
               put_en    = 1'b1;
               after_put = ST_ZERO;
            end
         end
         ST_LEN: begin
            put_en    = 1'b1;
            put_byte  = len_ff[{~cnt_ff, 3'b000} +: 8];
            cnt_in    = cnt_ff + 3'd1;
            after_put = (cnt_ff == 3'd7) ? ST_OUT : ST_LEN;
            out_idx_in = '0;
         end
         ST_COMP: begin
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[15] = w_next;
            work_in  = round_out;
            t_in     = (round_ff == 6'd15) ? T_HIGH_R16 : rotl(t_ff, 1);
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               cv_in[0] = cv_ff[0] ^ round_out.a;
               cv_in[1] = cv_ff[1] ^ round_out.b;
               cv_in[2] = cv_ff[2] ^ round_out.c;
               cv_in[3] = cv_ff[3] ^ round_out.d;
               cv_in[4] = cv_ff[4] ^ round_out.e;
               cv_in[5] = cv_ff[5] ^ round_out.f;
               cv_in[6] = cv_ff[6] ^ round_out.g;
               cv_in[7] = cv_ff[7] ^ round_out.h;
               state_in = ret_ff;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  cv_in    = IV;
                  len_in   = '0;
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // byte write into the window, block full starts a compression
      if (put_en) begin
         w_in[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] = put_byte;
         fill_in  = fill_ff + 6'd1;
         state_in = after_put;
         if (fill_ff == 6'd63) begin
            ret_in   = after_put;
            state_in = ST_COMP;
            round_in = '0;
            t_in     = T_LOW;
            work_in  = '{cv_ff[0], cv_ff[1], cv_ff[2], cv_ff[3],
                         cv_ff[4], cv_ff[5], cv_ff[6], cv_ff[7]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ret_ff     <= ST_IDLE;
         cv_ff      <= IV;
         work_ff    <= '0;
         fill_ff    <= '0;
         round_ff   <= '0;
         len_ff     <= '0;
         cnt_ff     <= '0;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         cv_ff      <= cv_in;
         work_ff    <= work_in;
         fill_ff    <= fill_in;
         round_ff   <= round_in;
         len_ff     <= len_in;
         cnt_ff     <= cnt_in;
         out_idx_ff <= out_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      w_ff      <= w_in;
      t_ff      <= t_in;
      word_ff   <= word_in;
      nbytes_ff <= nbytes_in;
      last_ff   <= last_in;
   end

`ifndef SYNTHESIS
   // never take a word while digest words are on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req_ready high during digest output");

   // a compression ends after its 64th round and never chains into another
   a_comp_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP && round_ff == 6'd63) |=> (state_ff != ST_COMP))
      else $error("compression did not end after round 63");

   // after the eighth digest word the engine is idle with an empty block
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_payload.digest_last)
         |=> (req_ready && fill_ff == 6'd0 && len_ff == 64'd0))
      else $error("engine not cleared after digest");
`endif

endmodule
